// ===== rtl/adbr_pkg.sv =====
// Shared types, constants and helpers for the accelerometer average/deadband/remap block.
package adbr_pkg;

    localparam int AVG_COUNT = 5;

    localparam int RAW_W  = 8;
    localparam int AXIS_W = 16;
    localparam int BAND_W = 14;
    localparam int ORI_W  = 3;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_BAND   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = CFG_IDX_W'(1);

    localparam logic [BAND_W-1:0] HOLD_BAND_RST   = BAND_W'(770);
    localparam logic [ORI_W-1:0]  ORIENTATION_RST = ORI_W'(4);

    localparam int ALERT_BIT = 6;

    // Running sums, wide enough for AVG_COUNT scaled samples.
    localparam int SUM_W = AXIS_W + $clog2(AVG_COUNT);
    localparam int CNT_W = $clog2(AVG_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_COUNT - 1);

    // Divide by AVG_COUNT: exact for magnitudes below 2**MAG_W.
    localparam int MAG_W     = SUM_W;
    localparam int DIV_L     = $clog2(AVG_COUNT);
    localparam int DIV_SHIFT = MAG_W + DIV_L;
    localparam int RECIP_W   = MAG_W + 1;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((longint'(1) << DIV_SHIFT) + longint'(AVG_COUNT) - 1) / AVG_COUNT);

    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef struct packed {
        logic [BAND_W-1:0] hold_band;
        logic [ORI_W-1:0]  orientation;
    } t_cfg;

    // Sign-extend the 6-bit field and scale by 768.
    function automatic t_axis scale_field(input logic [RAW_W-1:0] b);
        t_axis e;
        e = AXIS_W'(signed'(b[5:0]));
        return (e <<< 9) + (e <<< 8);
    endfunction

endpackage

// ===== rtl/adbr_accum.sv =====
// Input register and per-axis accumulation of good samples.
module adbr_accum import adbr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [RAW_W-1:0] i_raw_x,
    input  logic [RAW_W-1:0] i_raw_y,
    input  logic [RAW_W-1:0] i_raw_z,
    output logic             o_valid,
    input  logic             i_ready,
    output t_sum             o_sum [3]
);

    logic             r_v1;
    logic [RAW_W-1:0] r_raw [3];
    logic             r_v2;
    t_sum             r_sum [3];
    t_sum             r_acc [3];
    t_cnt             r_cnt;

    logic take2;
    logic alert;
    logic last;
    t_sum n_acc [3];

    assign take2   = !r_v2 || i_ready;
    assign o_ready = !r_v1 || take2;
    assign alert   = r_raw[0][ALERT_BIT] | r_raw[1][ALERT_BIT] | r_raw[2][ALERT_BIT];
    assign last    = (r_cnt == CNT_LAST);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = r_acc[i] + SUM_W'(scale_field(r_raw[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_cnt <= '0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (take2) begin
                r_v2 <= r_v1 && !alert && last;
            end
            if (take2 && r_v1 && !alert) begin
                if (last) begin
                    r_cnt <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_acc[i] <= '0;
                    end
                end else begin
                    r_cnt <= CNT_W'(r_cnt + 1'b1);
                    for (int i = 0; i < 3; i++) begin
                        r_acc[i] <= n_acc[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_raw[0] <= i_raw_x;
            r_raw[1] <= i_raw_y;
            r_raw[2] <= i_raw_z;
        end
        if (take2) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= n_acc[i];
            end
        end
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;

endmodule

// ===== rtl/adbr_divide.sv =====
// Divide of each group sum by the sample count, truncating toward zero.
module adbr_divide import adbr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_sum  i_sum [3],
    output logic  o_valid,
    input  logic  i_ready,
    output t_axis o_avg [3]
);

    logic  r_v3;
    t_axis r_avg [3];

    logic              neg  [3];
    logic [MAG_W-1:0]  mag  [3];
    logic [PROD_W-1:0] prod [3];
    logic [AXIS_W-1:0] quot [3];
    t_axis             n_avg [3];

    assign o_ready = !r_v3 || i_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg[i]   = i_sum[i][SUM_W-1];
            mag[i]   = neg[i] ? MAG_W'(-i_sum[i]) : MAG_W'(i_sum[i]);
            prod[i]  = PROD_W'(mag[i]) * PROD_W'(DIV_RECIP);
            quot[i]  = prod[i][DIV_SHIFT +: AXIS_W];
            n_avg[i] = neg[i] ? t_axis'(-quot[i]) : t_axis'(quot[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (o_ready) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_avg <= n_avg;
        end
    end

    assign o_valid = r_v3;
    assign o_avg   = r_avg;

endmodule

// ===== rtl/adbr_deadband.sv =====
// Per-axis deadband with hysteresis, orientation remap and result register.
module adbr_deadband import adbr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_axis i_avg [3],
    input  t_cfg  i_cfg,
    output logic  o_valid,
    input  logic  i_ready,
    output t_axis o_x,
    output t_axis o_y,
    output t_axis o_z
);

    localparam int D_W = AXIS_W + 2;

    logic  r_valid;
    logic  r_first_done;
    t_axis r_held [3];
    t_axis r_x;
    t_axis r_y;
    t_axis r_z;

    logic                  go;
    logic signed [D_W-1:0] band;
    logic signed [D_W-1:0] band2;
    t_axis                 base [3];
    logic signed [D_W-1:0] d    [3];
    logic signed [D_W-1:0] dadj [3];
    logic signed [D_W-1:0] dh   [3];
    logic                  in_band [3];
    logic                  half    [3];
    t_axis                 n_held  [3];
    t_axis                 v       [3];
    t_axis                 r0;
    t_axis                 r1;
    t_axis                 r2;

    assign go      = !r_valid || i_ready;
    assign o_ready = go;

    assign band  = signed'(D_W'(i_cfg.hold_band));
    assign band2 = band <<< 1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            base[i]    = r_first_done ? r_held[i] : i_avg[i];
            d[i]       = D_W'(i_avg[i]) - D_W'(base[i]);
            dadj[i]    = d[i] + signed'({{(D_W-1){1'b0}}, d[i][D_W-1]});
            dh[i]      = dadj[i] >>> 1;
            in_band[i] = (d[i] < band) && (d[i] > -band);
            half[i]    = ((d[i] > band) && (d[i] < band2)) ||
                         ((d[i] < -band) && (d[i] > -band2));
            if (in_band[i]) begin
                n_held[i] = base[i];
            end else if (half[i]) begin
                n_held[i] = base[i] + AXIS_W'(dh[i]);
            end else begin
                n_held[i] = i_avg[i];
            end
        end
        v[0] = n_held[0];
        v[1] = n_held[1];
        v[2] = -n_held[2];
    end

    always_comb begin
        unique case (i_cfg.orientation)
            3'd0: begin r0 = -v[0]; r1 = -v[1]; r2 =  v[2]; end
            3'd1: begin r0 =  v[1]; r1 = -v[0]; r2 =  v[2]; end
            3'd2: begin r0 =  v[0]; r1 =  v[1]; r2 =  v[2]; end
            3'd3: begin r0 = -v[1]; r1 =  v[0]; r2 =  v[2]; end
            3'd4: begin r0 = -v[0]; r1 =  v[1]; r2 = -v[2]; end
            3'd5: begin r0 =  v[1]; r1 =  v[0]; r2 = -v[2]; end
            3'd6: begin r0 =  v[0]; r1 = -v[1]; r2 = -v[2]; end
            default: begin r0 = -v[1]; r1 = -v[0]; r2 = -v[2]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_first_done <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_held[i] <= '0;
            end
        end else if (go) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_first_done <= 1'b1;
                r_held       <= n_held;
            end
        end
    end

    // X and Y swap on the way out.
    always_ff @(posedge i_clk) begin
        if (go && i_valid) begin
            r_x <= r1;
            r_y <= r0;
            r_z <= r2;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== rtl/accel_average_deadband_remap.sv =====
// Top level: accelerometer averaging, deadband and orientation remap.
//
// Input channel (i_in_valid / o_in_ready) takes one three-axis sample of raw
// register bytes per cycle while o_in_ready is high. A sample with an alert
// bit set is dropped. Every AVG_COUNT good samples produce one result on the
// output channel (o_out_valid / i_out_ready); other samples produce none.
// Pipeline: input register, accumulate register, divide register, result
// register. The last sample of a group moves through these registers in order;
// its result is valid once it reaches the result register.
// Throughput: one item per cycle. Each stage holds its item only while the
// stage after it is full and not moving, so a waiting result still lets
// items enter until the pipeline is full; then o_in_ready drops.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
// deadband half width, index 1 the orientation; other indexes are ignored.
// Write only while the block is idle.
// Reset clears sums, sample count, held values and the first-average flag,
// loads hold_band = 770 and orientation = 4, and empties the pipeline.
module accel_average_deadband_remap import adbr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [RAW_W-1:0]      i_raw_x,
    input  logic [RAW_W-1:0]      i_raw_y,
    input  logic [RAW_W-1:0]      i_raw_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [AXIS_W-1:0] o_out_x,
    output logic signed [AXIS_W-1:0] o_out_y,
    output logic signed [AXIS_W-1:0] o_out_z,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  sum_valid;
    logic  sum_ready;
    t_sum  sum [3];
    logic  avg_valid;
    logic  avg_ready;
    t_axis avg [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_band   <= HOLD_BAND_RST;
            r_cfg.orientation <= ORIENTATION_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HOLD_BAND:   r_cfg.hold_band   <= i_cfg_data[BAND_W-1:0];
                CFG_ORIENTATION: r_cfg.orientation <= i_cfg_data[ORI_W-1:0];
                default: ;
            endcase
        end
    end

    adbr_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_raw_x (i_raw_x),
        .i_raw_y (i_raw_y),
        .i_raw_z (i_raw_z),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_sum   (sum)
    );

    adbr_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_sum   (sum),
        .o_valid (avg_valid),
        .i_ready (avg_ready),
        .o_avg   (avg)
    );

    adbr_deadband u_deadband (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (avg_valid),
        .o_ready (avg_ready),
        .i_avg   (avg),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z)
    );

endmodule

// ===== rtl/adbr_checker.sv =====
// Port-level assertions for the top level, attached by bind.
module adbr_checker import adbr_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [AXIS_W-1:0] o_out_x,
    input logic signed [AXIS_W-1:0] o_out_y,
    input logic signed [AXIS_W-1:0] o_out_z
);

    localparam logic signed [AXIS_W-1:0] OUT_MAX = AXIS_W'(24576);
    localparam logic signed [AXIS_W-1:0] OUT_MIN = -OUT_MAX;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z))
        else $error("result changed while stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_x >= OUT_MIN && o_out_x <= OUT_MAX &&
                        o_out_y >= OUT_MIN && o_out_y <= OUT_MAX &&
                        o_out_z >= OUT_MIN && o_out_z <= OUT_MAX)
        else $error("result out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind accel_average_deadband_remap adbr_checker u_adbr_checker (.*);

// ===== verif/testbench.sv =====
// Testbench for accel_average_deadband_remap: directed and random items against a predictor.
`timescale 1ns / 1ps

module testbench;
    import adbr_pkg::*;

    localparam int SCALE        = 768;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = '1;

    typedef struct packed {
        t_axis x;
        t_axis y;
        t_axis z;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [RAW_W-1:0]      i_raw_x = '0;
    logic [RAW_W-1:0]      i_raw_y = '0;
    logic [RAW_W-1:0]      i_raw_z = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_axis                 o_out_x;
    t_axis                 o_out_y;
    t_axis                 o_out_z;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    accel_average_deadband_remap dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int                acc_sum [3];
    int                acc_count;
    int                held_axis [3];
    bit                seen_first;
    logic [BAND_W-1:0] band_reg;
    logic [ORI_W-1:0]  orient_reg;

    t_result pending_results [$];
    int      errors;
    int      in_idle_pct = 6;
    int      out_idle_pct = 6;
    int      walk_base [3];
    int      stall_cycles;

    function automatic int scaled_field(input logic [RAW_W-1:0] b);
        int v;
        v = int'(b[5:0]);
        if (b[5]) v -= 64;
        return v * SCALE;
    endfunction

    function automatic int deadband_axis(input int k, input int avg);
        int band;
        int d;
        band = int'(band_reg);
        d = avg - held_axis[k];
        if (d < band && d > -band) return held_axis[k];
        if ((d > band && d < 2 * band) || (d < -band && d > -2 * band))
            held_axis[k] = held_axis[k] + d / 2;
        else
            held_axis[k] = avg;
        return held_axis[k];
    endfunction

    function automatic t_result remap_axes(input int ax, input int ay, input int az);
        int a;
        int b;
        int r0;
        int r1;
        int r2;
        t_result res;
        a = orient_reg[0] ? ay : ax;
        b = orient_reg[0] ? ax : ay;
        r0 = (orient_reg[1] == orient_reg[0]) ? -a : a;
        r1 = (orient_reg[2] == orient_reg[1]) ? -b : b;
        r2 = orient_reg[2] ? az : -az;
        res.x = AXIS_W'(r1);
        res.y = AXIS_W'(r0);
        res.z = AXIS_W'(r2);
        return res;
    endfunction

    task automatic accumulate_sample(input logic [RAW_W-1:0] x, y, z);
        int avg [3];
        int k;
        if (x[ALERT_BIT] || y[ALERT_BIT] || z[ALERT_BIT]) return;
        acc_sum[0] += scaled_field(x);
        acc_sum[1] += scaled_field(y);
        acc_sum[2] += scaled_field(z);
        acc_count++;
        if (acc_count < AVG_COUNT) return;
        for (k = 0; k < 3; k++) begin
            avg[k] = acc_sum[k] / AVG_COUNT;
            acc_sum[k] = 0;
        end
        acc_count = 0;
        if (!seen_first) begin
            for (k = 0; k < 3; k++) held_axis[k] = avg[k];
            seen_first = 1'b1;
        end
        for (k = 0; k < 3; k++) avg[k] = deadband_axis(k, avg[k]);
        pending_results.push_back(remap_axes(avg[0], avg[1], avg[2]));
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] x, y, z);
        @(negedge i_clk);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_x <= x;
        i_raw_y <= y;
        i_raw_z <= z;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        accumulate_sample(x, y, z);
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_HOLD_BAND) band_reg = data[BAND_W-1:0];
        else if (idx == CFG_ORIENTATION) orient_reg = data[ORI_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_random_band;
        logic [BAND_W-1:0] band;
        case ($urandom_range(5))
            0: band = '0;
            1: band = '1;
            2: band = BAND_W'(SCALE);
            3: band = BAND_W'(2 * SCALE);
            default: band = BAND_W'($urandom_range(3000));
        endcase
        write_reg(CFG_HOLD_BAND, {2'($urandom_range(3)), band});
    endtask

    task automatic send_random(input int count);
        logic [RAW_W-1:0] b [3];
        int mode;
        int k;
        repeat (count) begin
            mode = $urandom_range(99);
            for (k = 0; k < 3; k++) begin
                if ($urandom_range(99) < 3) walk_base[k] = $urandom_range(63);
                if (mode < 30)
                    b[k] = RAW_W'($urandom_range(255));
                else
                    b[k] = {1'($urandom), 1'b0,
                            6'(walk_base[k] + $urandom_range(4) - 2)};
                if (mode >= 7) b[k][ALERT_BIT] = 1'b0;
            end
            if (mode < 7) b[$urandom_range(2)][ALERT_BIT] = 1'b1;
            send_sample(b[0], b[1], b[2]);
        end
    endtask

    // alerts on each axis, bit 7 ignored, field extremes; first group loads held value
    task automatic test_first_average;
        send_sample(8'h40, 8'h00, 8'h00);
        send_sample(8'h00, 8'h7F, 8'h00);
        send_sample(8'h80, 8'h00, 8'hC0);
        send_sample(8'h20, 8'h1F, 8'h3F);
        send_sample(8'h1F, 8'h20, 8'h00);
        send_sample(8'h00, 8'h3F, 8'h20);
        send_sample(8'h3F, 8'h00, 8'h1F);
        send_sample(8'hBF, 8'h9F, 8'hA0);
    endtask

    task automatic test_zero_band;
        drain_results();
        write_reg(CFG_HOLD_BAND, 16'hC000);
        write_reg(CFG_IDX_NONE, 16'hFFFF);
        repeat (AVG_COUNT) send_sample(8'h00, 8'h00, 8'h00);
    endtask

    // x hits the band edge, y twice the band, z the halfway band; then inside,
    // negative twice-band and negative halfway
    task automatic test_band_edges;
        drain_results();
        write_reg(CFG_HOLD_BAND, CFG_DATA_W'(SCALE));
        send_sample(8'h01, 8'h02, 8'h01);
        send_sample(8'h01, 8'h02, 8'h01);
        send_sample(8'h01, 8'h02, 8'h01);
        send_sample(8'h01, 8'h02, 8'h02);
        send_sample(8'h01, 8'h02, 8'h02);
        send_sample(8'h01, 8'h00, 8'h3F);
        send_sample(8'h01, 8'h00, 8'h3F);
        send_sample(8'h01, 8'h00, 8'h3F);
        send_sample(8'h01, 8'h00, 8'h3F);
        send_sample(8'h01, 8'h00, 8'h00);
    endtask

    task automatic test_orientations;
        int o;
        for (o = 0; o < 8; o++) begin
            drain_results();
            write_reg(CFG_ORIENTATION, {13'($urandom), 3'(o)});
            write_random_band();
            send_random(20);
        end
    endtask

    task automatic test_random_traffic;
        repeat (10) begin
            drain_results();
            if ($urandom_range(1)) write_random_band();
            if ($urandom_range(1)) write_reg(CFG_ORIENTATION, 16'($urandom));
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom));
            send_random(30);
        end
    endtask

    task automatic test_full_rate;
        drain_results();
        write_reg(CFG_HOLD_BAND, 16'h3FFF);
        write_reg(CFG_ORIENTATION, 16'h0007);
        in_idle_pct = 0;
        out_idle_pct = 0;
        send_random(100);
        drain_results();
        in_idle_pct = 6;
        out_idle_pct = 6;
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d",
                         $time, o_out_x, o_out_y, o_out_z);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out_x !== exp_res.x) begin
                    $display("%0t: out_x expected %0d actual %0d", $time, exp_res.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== exp_res.y) begin
                    $display("%0t: out_y expected %0d actual %0d", $time, exp_res.y, o_out_y);
                    errors++;
                end
                if (o_out_z !== exp_res.z) begin
                    $display("%0t: out_z expected %0d actual %0d", $time, exp_res.z, o_out_z);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int k;
        errors = 0;
        stall_cycles = 0;
        acc_count = 0;
        seen_first = 1'b0;
        band_reg = HOLD_BAND_RST;
        orient_reg = ORIENTATION_RST;
        for (k = 0; k < 3; k++) begin
            acc_sum[k] = 0;
            held_axis[k] = 0;
            walk_base[k] = $urandom_range(63);
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_average();
        test_zero_band();
        test_band_edges();
        test_orientations();
        test_random_traffic();
        test_full_rate();
        drain_results();

        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
